// ----- src/line_point_generator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// line_point_generator_unit_macros
// assertion macros used by the line point generator unit
// ----------------------------------------------------------------------------
`ifndef LINE_POINT_GENERATOR_UNIT_MACROS_SVH
`define LINE_POINT_GENERATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds on every clock edge out of reset
`define LPG_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed: always");

// antecedent implies consequent in the same cycle
`define LPG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same cycle implication");

// antecedent implies consequent in the next cycle
`define LPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle implication");

`else

`define LPG_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define LPG_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define LPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/lpg_pkg.sv -----
// ----------------------------------------------------------------------------
// lpg_pkg
// shared constants and types of the line point generator
// ----------------------------------------------------------------------------
package lpg_pkg;

    // coordinate width of every endpoint and point
    localparam int COORD_WIDTH = 6;

    // operands of one step of the remainder unit
    typedef struct packed {
        logic [COORD_WIDTH-1:0]        rem;
        logic [COORD_WIDTH-1:0]        v;
        logic signed [COORD_WIDTH:0]   delta;
        logic [COORD_WIDTH-1:0]        span;
    } t_step_in;

    // result of one step of the remainder unit
    typedef struct packed {
        logic [COORD_WIDTH-1:0] rem;
        logic [COORD_WIDTH-1:0] v;
    } t_step_res;

endpackage

// ----- src/lpg_step.sv -----
// ----------------------------------------------------------------------------
// lpg_step
// one step of the slope remainder: adds the signed minor-axis delta to the running
// remainder and folds it back into [0, span), moving v by one if needed
// ----------------------------------------------------------------------------
module lpg_step (
    input  lpg_pkg::t_step_in  i_step,
    output lpg_pkg::t_step_res o_step
);
    import lpg_pkg::*;

    logic signed [COORD_WIDTH+1:0] sum;
    logic signed [COORD_WIDTH+1:0] span_s;

    // running remainder plus signed delta
    assign span_s = $signed({2'b00, i_step.span});
    assign sum    = $signed({2'b00, i_step.rem})
                  + $signed({i_step.delta[COORD_WIDTH], i_step.delta});

    // fold back into range, one correction is enough since |delta| <= span
    always_comb begin
        if (sum >= span_s) begin
            o_step.rem = COORD_WIDTH'(sum - span_s);
            o_step.v   = COORD_WIDTH'(i_step.v + 1'b1);
        end else if (sum < 0) begin
            o_step.rem = COORD_WIDTH'(sum + span_s);
            o_step.v   = COORD_WIDTH'(i_step.v - 1'b1);
        end else begin
            o_step.rem = COORD_WIDTH'(sum);
            o_step.v   = i_step.v;
        end
    end

endmodule

// ----- src/line_point_generator_unit.sv -----
// ----------------------------------------------------------------------------
// line_point_generator_unit
// emits every raster point of a line between two endpoints, stepping the
// major axis from its smaller end and tracking the minor axis by remainder
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_stall   | x_start y_start x_end y_end
//   out     | output    | o_out_valid / i_out_stall | point_x point_y is_last
//
// a request passes through a setup state, then span + 1 points, one per cycle when
// the output is not stalled; span is the larger of the two axis spans
// the next request is taken the cycle after the last point is delivered
// an output stall holds the current point; the remainder unit steps only
// when a point is taken
// reset is synchronous, active low, and returns the sequencer to idle
// ----------------------------------------------------------------------------
`include "line_point_generator_unit_macros.svh"

module line_point_generator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [lpg_pkg::COORD_WIDTH-1:0] i_x_start,
    input  logic [lpg_pkg::COORD_WIDTH-1:0] i_y_start,
    input  logic [lpg_pkg::COORD_WIDTH-1:0] i_x_end,
    input  logic [lpg_pkg::COORD_WIDTH-1:0] i_y_end,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lpg_pkg::COORD_WIDTH-1:0] o_point_x,
    output logic [lpg_pkg::COORD_WIDTH-1:0] o_point_y,
    output logic                         o_is_last
);
    import lpg_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic [COORD_WIDTH-1:0]        r_x0, r_y0, r_x1, r_y1;
    logic [COORD_WIDTH-1:0]        r_u, n_u;
    logic [COORD_WIDTH-1:0]        r_ub, n_ub;
    logic [COORD_WIDTH-1:0]        r_v, n_v;
    logic [COORD_WIDTH-1:0]        r_rem, n_rem;
    logic [COORD_WIDTH-1:0]        r_span, n_span;
    logic signed [COORD_WIDTH:0]   r_delta, n_delta;
    logic                          r_major, n_major;

    logic [COORD_WIDTH-1:0]        dx, dy;
    logic                          major;
    logic [COORD_WIDTH-1:0]        ua, va, ub, vb;
    logic                          in_take, out_take, last;
    t_step_in                      step_in;
    t_step_res                     step_res;

    // handshakes
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == ST_RUN);
    assign out_take    = o_out_valid && !i_out_stall;
    assign last        = (r_u == r_ub);

    // current point, axes swapped back for y-major lines
    assign o_point_x = r_major ? r_u : r_v;
    assign o_point_y = r_major ? r_v : r_u;
    assign o_is_last = last;

    // setup: spans, major axis and ordering of the endpoints
    always_comb begin
        dx    = (r_x1 > r_x0) ? r_x1 - r_x0 : r_x0 - r_x1;
        dy    = (r_y1 > r_y0) ? r_y1 - r_y0 : r_y0 - r_y1;
        major = (dx >= dy);
        if (major) begin
            ua = r_x0; va = r_y0; ub = r_x1; vb = r_y1;
        end else begin
            ua = r_y0; va = r_x0; ub = r_y1; vb = r_x1;
        end
        if (ub < ua) begin
            {ua, ub} = {ub, ua};
            {va, vb} = {vb, va};
        end
    end

    // remainder step unit
    assign step_in.rem   = r_rem;
    assign step_in.v     = r_v;
    assign step_in.delta = r_delta;
    assign step_in.span  = r_span;

    lpg_step u_step (
        .i_step (step_in),
        .o_step (step_res)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_u     = r_u;
        n_ub    = r_ub;
        n_v     = r_v;
        n_rem   = r_rem;
        n_span  = r_span;
        n_delta = r_delta;
        n_major = r_major;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_u     = ua;
                n_ub    = ub;
                n_v     = va;
                n_rem   = '0;
                n_span  = major ? dx : dy;
                n_delta = $signed({1'b0, vb}) - $signed({1'b0, va});
                n_major = major;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (out_take) begin
                    if (last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_u   = COORD_WIDTH'(r_u + 1'b1);
                        n_v   = step_res.v;
                        n_rem = step_res.rem;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture and stepping datapath
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_x0 <= i_x_start;
            r_y0 <= i_y_start;
            r_x1 <= i_x_end;
            r_y1 <= i_y_end;
        end
        r_u     <= n_u;
        r_ub    <= n_ub;
        r_v     <= n_v;
        r_rem   <= n_rem;
        r_span  <= n_span;
        r_delta <= n_delta;
        r_major <= n_major;
    end

    // checks
    `LPG_ASSERT_SAME(a_rem_range, i_clk, i_rst_n, (r_state == ST_RUN) && (r_span != '0), r_rem < r_span)
    `LPG_ASSERT_SAME(a_u_bound, i_clk, i_rst_n, r_state == ST_RUN, r_u <= r_ub)
    `LPG_ASSERT_NEXT(a_u_step, i_clk, i_rst_n, out_take && !last, r_u == COORD_WIDTH'($past(r_u) + 1'b1))
    `LPG_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, out_take && last, !o_out_valid && !o_in_stall)

endmodule
